// File: rtl/core/abst_pkg.sv
// ----------------------------------------------------------------------------
// abst_pkg
// Shared constants, codes and types for the implicit-array BST unit.
// ----------------------------------------------------------------------------
package abst_pkg;

    localparam int LEVELS  = 6;
    localparam int SLOTS   = (1 << LEVELS) - 1;
    localparam int ADDR_W  = LEVELS;
    localparam int IDX_W   = LEVELS + 1;
    localparam int KEY_W   = 8;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 6;

    localparam logic [IDX_W-1:0] SLOTS_IDX = IDX_W'(SLOTS);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POST   = 2'd2;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd2;
    localparam logic [STAT_W-1:0] ST_NODE     = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_EVAL,
        S_TRV_RD,
        S_TRV_EVAL,
        S_TRV_UP,
        S_TRV_PRD,
        S_TRV_PEVAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  node_key;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } res_t;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        return SLOT_W'(idx);
    endfunction

    function automatic res_t make_res(input logic [STAT_W-1:0] status,
                                      input logic [KEY_W-1:0]  node_key,
                                      input logic [IDX_W-1:0]  idx);
        res_t r;
        r.status   = status;
        r.node_key = node_key;
        r.slot     = to_slot(idx);
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/core/abst_ram.sv
// ----------------------------------------------------------------------------
// abst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module abst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/abst_engine.sv
// ----------------------------------------------------------------------------
// abst_engine
// Sequencer for insert walks and stackless pre/post-order traversals over
// the slot RAM. Holds one result back so the final one can carry last.
// ----------------------------------------------------------------------------
module abst_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [abst_pkg::CMD_W-1:0] cmd,
    input  logic [abst_pkg::KEY_W-1:0] key,
    output logic                       res_valid,
    input  logic                       res_stall,
    output abst_pkg::res_t             res
);

    import abst_pkg::*;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic                post_reg, post_next;
    res_t                pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [SLOTS-1:0]    occ_reg;
    logic                occ_q_reg;

    logic                ram_re;
    logic                ram_we;
    logic [ADDR_W-1:0]   addr;
    logic [KEY_W-1:0]    ram_rdata;
    logic [KEY_W-1:0]    node;
    logic [IDX_W-1:0]    left_idx;
    logic [IDX_W-1:0]    right_idx;
    logic [IDX_W-1:0]    parent_idx;
    res_t                pend_last;

    assign addr       = idx_reg[ADDR_W-1:0];
    assign node       = occ_q_reg ? ram_rdata : '0;
    assign left_idx   = {idx_reg[IDX_W-2:0], 1'b1};
    assign right_idx  = {idx_reg[IDX_W-2:0] + 1'b1, 1'b0};
    assign parent_idx = {1'b0, idx_reg[IDX_W-1:1] - 1'b1};

    abst_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg        <= '0;
            occ_q_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                occ_reg[addr] <= 1'b1;
            end
            if (ram_re)
            begin
                occ_q_reg <= occ_reg[addr];
            end
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        key_reg  <= key_next;
        post_reg <= post_next;
        pend_reg <= pend_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        prev_next       = prev_reg;
        key_next        = key_reg;
        post_next       = post_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        item_stall      = 1'b1;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        res_valid       = 1'b0;
        pend_last       = pend_reg;
        pend_last.last  = 1'b1;
        res             = pend_reg;
        res.last        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    case (cmd)
                        CMD_INSERT:
                        begin
                            key_next  = key;
                            idx_next  = '0;
                            prev_next = '0;
                            if (key == '0)
                            begin
                                pend_next  = make_res(ST_DUP, '0, '0);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_INS_RD;
                            end
                        end
                        CMD_PRE, CMD_POST:
                        begin
                            post_next       = (cmd == CMD_POST);
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_TRV_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_INS_RD:
            begin
                if (idx_reg >= SLOTS_IDX)
                begin
                    pend_next  = make_res(ST_OVERFLOW, key_reg, prev_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_INS_EVAL;
                end
            end

            S_INS_EVAL:
            begin
                if (node == '0)
                begin
                    ram_we     = 1'b1;
                    pend_next  = make_res(ST_INSERTED, key_reg, idx_reg);
                    state_next = S_DONE;
                end
                else if (node == key_reg)
                begin
                    pend_next  = make_res(ST_DUP, key_reg, idx_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next  = idx_reg;
                    idx_next   = (key_reg > node) ? right_idx : left_idx;
                    state_next = S_INS_RD;
                end
            end

            S_TRV_RD:
            begin
                if (idx_reg >= SLOTS_IDX)
                begin
                    state_next = S_TRV_UP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_TRV_EVAL;
                end
            end

            S_TRV_EVAL:
            begin
                if (node == '0)
                begin
                    if (idx_reg == '0)
                    begin
                        pend_next  = make_res(ST_EMPTY, '0, '0);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_TRV_UP;
                    end
                end
                else if (post_reg)
                begin
                    idx_next   = left_idx;
                    state_next = S_TRV_RD;
                end
                else
                begin
                    res_valid = pend_valid_reg;
                    if (!(pend_valid_reg && res_stall))
                    begin
                        pend_next       = make_res(ST_NODE, node, idx_reg);
                        pend_valid_next = 1'b1;
                        idx_next        = left_idx;
                        state_next      = S_TRV_RD;
                    end
                end
            end

            S_TRV_UP:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (idx_reg[0])
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TRV_RD;
                end
                else
                begin
                    idx_next = parent_idx;
                    if (post_reg)
                    begin
                        state_next = S_TRV_PRD;
                    end
                end
            end

            S_TRV_PRD:
            begin
                ram_re     = 1'b1;
                state_next = S_TRV_PEVAL;
            end

            S_TRV_PEVAL:
            begin
                res_valid = pend_valid_reg;
                if (!(pend_valid_reg && res_stall))
                begin
                    pend_next       = make_res(ST_NODE, node, idx_reg);
                    pend_valid_next = 1'b1;
                    state_next      = S_TRV_UP;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                res       = pend_last;
                if (!res_stall)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/array_bst_insert_traverse_unit.sv
// ----------------------------------------------------------------------------
// array_bst_insert_traverse_unit
// Implicit-array binary search tree of byte keys with insert and dumps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_stall carries cmd and key: insert (key),
//   pre-order dump or post-order dump. Code 3 is dropped without a result.
//   Result channel result_valid/result_stall carries status, node_key, slot
//   and last; last marks the final result of an item.
//   One item is worked at a time. An insert costs one slot RAM read per
//   tree level walked, and its result then passes the output register. A
//   dump reads, checks and climbs for each occupied node and each empty
//   child slot inside the array; a child slot past the end of the array
//   is climbed from without a read, and in post-order each node is read
//   again on the way up before its result is handed over. All reads go
//   through the single slot RAM read port.
//   Each result is held back one step so last can be set, then passes an
//   output register; a stalled receiver holds the result and the engine
//   waits, and the next item is taken once the last result has left the
//   engine.
//   Reset clears the tree at once through per-slot occupancy flags; the
//   unit is ready to take an item as soon as reset is released.
// ----------------------------------------------------------------------------
module array_bst_insert_traverse_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [abst_pkg::CMD_W-1:0]  cmd,
    input  logic [abst_pkg::KEY_W-1:0]  key,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [abst_pkg::STAT_W-1:0] status,
    output logic [abst_pkg::KEY_W-1:0]  node_key,
    output logic [abst_pkg::SLOT_W-1:0] slot,
    output logic                        last
);

    import abst_pkg::*;

    logic eng_valid;
    logic eng_stall;
    res_t eng_res;
    logic out_valid_reg;
    res_t out_res_reg;

    abst_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (cmd),
        .key        (key),
        .res_valid  (eng_valid),
        .res_stall  (eng_stall),
        .res        (eng_res)
    );

    assign eng_stall = out_valid_reg && result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!eng_stall)
        begin
            out_valid_reg <= eng_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!eng_stall && eng_valid)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_res_reg.status;
    assign node_key     = out_res_reg.node_key;
    assign slot         = out_res_reg.slot;
    assign last         = out_res_reg.last;

endmodule

// File: tb/array_bst_insert_traverse_unit_test.sv
// ----------------------------------------------------------------------------
// array_bst_insert_traverse_unit_test
// Self-checking bench for the implicit-array BST insert and dump unit.
// Items (insert, pre-order dump, post-order dump, dropped code) are pushed
// from a queue with random gaps, results are taken with random stalls, and
// every result is checked field by field against a local tree model that
// replays each accepted item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_bst_insert_traverse_unit_test;

    import abst_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int LIMIT      = 1_000_000;
    localparam int TAIL       = 100;
    localparam int CALM_START = 2000;
    localparam int CALM_END   = 5000;

    typedef struct {
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] val;
        bit               hold;
    } item_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    logic [CMD_W-1:0]    cmd          = '0;
    logic [KEY_W-1:0]    key          = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [STAT_W-1:0]   status;
    logic [KEY_W-1:0]    node_key;
    logic [SLOT_W-1:0]   slot;
    logic                last;

    item_t         pending_items[$];
    item_t         next_item;
    res_t          tree_results[$];
    res_t          want_res;
    logic [KEY_W-1:0] tree_mem [SLOTS] = '{default: '0};

    int cycles      = 0;
    int exp_count   = 0;
    int got_count   = 0;
    int errors      = 0;
    int n_inserts   = 0;
    int n_dumps     = 0;
    int n_dropped   = 0;
    int st_tally [5] = '{default: 0};
    bit idle_ok;

    array_bst_insert_traverse_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .key          (key),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .node_key     (node_key),
        .slot         (slot),
        .last         (last)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    assign idle_ok = !(cycles >= CALM_START && cycles < CALM_END);

    task automatic note(input logic [STAT_W-1:0] st, input logic [KEY_W-1:0] k,
                        input int idx, input bit fin);
        res_t r;
        r.status   = st;
        r.node_key = k;
        r.slot     = SLOT_W'(idx);
        r.last     = fin;
        tree_results.push_back(r);
        exp_count++;
        st_tally[st]++;
    endtask

    task automatic tree_insert(input logic [KEY_W-1:0] k);
        int idx;
        int prev;
        bit done;
        idx  = 0;
        prev = 0;
        done = 1'b0;
        if (k == '0)
        begin
            note(ST_DUP, '0, 0, 1'b1);
        end
        else
        begin
            while (!done)
            begin
                if (idx >= SLOTS)
                begin
                    note(ST_OVERFLOW, k, prev, 1'b1);
                    done = 1'b1;
                end
                else if (tree_mem[idx] == '0)
                begin
                    tree_mem[idx] = k;
                    note(ST_INSERTED, k, idx, 1'b1);
                    done = 1'b1;
                end
                else if (tree_mem[idx] == k)
                begin
                    note(ST_DUP, k, idx, 1'b1);
                    done = 1'b1;
                end
                else
                begin
                    prev = idx;
                    idx  = (k > tree_mem[idx]) ? 2 * idx + 2 : 2 * idx + 1;
                end
            end
        end
    endtask

    // post-order comes out as the reverse of a node-right-left walk
    task automatic tree_dump(input bit post);
        int stack[$];
        int order[$];
        int idx;
        if (tree_mem[0] == '0)
        begin
            note(ST_EMPTY, '0, 0, 1'b1);
        end
        else
        begin
            stack.push_back(0);
            while (stack.size() > 0)
            begin
                idx = stack.pop_back();
                if (idx < SLOTS && tree_mem[idx] != '0)
                begin
                    order.push_back(idx);
                    if (post)
                    begin
                        stack.push_back(2 * idx + 1);
                        stack.push_back(2 * idx + 2);
                    end
                    else
                    begin
                        stack.push_back(2 * idx + 2);
                        stack.push_back(2 * idx + 1);
                    end
                end
            end
            if (post)
                order.reverse();
            foreach (order[i])
                note(ST_NODE, tree_mem[order[i]], order[i], i == order.size() - 1);
        end
    endtask

    task automatic apply_item(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k);
        case (op)
            CMD_INSERT:
            begin
                n_inserts++;
                tree_insert(k);
            end
            CMD_PRE:
            begin
                n_dumps++;
                tree_dump(1'b0);
            end
            CMD_POST:
            begin
                n_dumps++;
                tree_dump(1'b1);
            end
            default:
                n_dropped++;
        endcase
    endtask

    task automatic add_item(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
                            input bit hold);
        item_t it;
        it.op   = op;
        it.val  = k;
        it.hold = hold;
        pending_items.push_back(it);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            cmd        <= '0;
            key        <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                apply_item(cmd, key);
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() > 0
                    && !(idle_ok && $urandom_range(0, 99) < 12)
                    && !(pending_items[0].hold && exp_count != got_count))
                begin
                    next_item  = pending_items.pop_front();
                    item_valid <= 1'b1;
                    cmd        <= next_item.op;
                    key        <= next_item.val;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                got_count <= got_count + 1;
                if (tree_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: status=%0d key=%0d slot=%0d last=%0d",
                                 status, node_key, slot, last);
                end
                else
                begin
                    want_res = tree_results.pop_front();
                    if (status !== want_res.status || node_key !== want_res.node_key
                        || slot !== want_res.slot || last !== want_res.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("result %0d mismatch: expected status=%0d key=%0d slot=%0d last=%0d",
                                     got_count, want_res.status, want_res.node_key,
                                     want_res.slot, want_res.last);
                            $display("    got status=%0d key=%0d slot=%0d last=%0d",
                                     status, node_key, slot, last);
                        end
                    end
                end
            end
            result_stall <= idle_ok && ($urandom_range(0, 99) < 12);
        end
    end

    initial
    begin
        item_t it;
        int    r;
        bit    timed_out;

        // empty tree, dropped code, key zero
        add_item(CMD_PRE,    8'h00, 1'b0);
        add_item(CMD_POST,   8'hFF, 1'b0);
        add_item(CMD_NONE,   8'hFF, 1'b0);
        add_item(CMD_INSERT, 8'h00, 1'b0);
        add_item(CMD_INSERT, 8'h80, 1'b0);
        add_item(CMD_INSERT, 8'h80, 1'b0);
        add_item(CMD_INSERT, 8'hFF, 1'b0);
        add_item(CMD_INSERT, 8'h01, 1'b0);
        add_item(CMD_INSERT, 8'h40, 1'b0);
        add_item(CMD_INSERT, 8'hC0, 1'b0);
        add_item(CMD_PRE,    8'h00, 1'b0);
        add_item(CMD_POST,   8'h00, 1'b0);
        // descending chain under 255 runs to the bottom level, then overflows
        add_item(CMD_INSERT, 8'hFE, 1'b0);
        add_item(CMD_INSERT, 8'hFD, 1'b0);
        add_item(CMD_INSERT, 8'hFC, 1'b0);
        add_item(CMD_INSERT, 8'hFB, 1'b0);
        add_item(CMD_INSERT, 8'hFA, 1'b0);
        add_item(CMD_INSERT, 8'hFB, 1'b0);
        add_item(CMD_PRE,    8'h55, 1'b0);
        add_item(CMD_POST,   8'hAA, 1'b0);

        for (int n = 0; n < 390; n++)
        begin
            r       = $urandom_range(0, 99);
            it.hold = (n == 150 || n == 300);
            it.val  = $urandom_range(1, 255);
            if (r < 2)
            begin
                it.op  = CMD_INSERT;
                it.val = '0;
            end
            else if (r < 5)
            begin
                it.op  = CMD_NONE;
                it.val = $urandom;
            end
            else if (r < 13)
                it.op = CMD_PRE;
            else if (r < 21)
                it.op = CMD_POST;
            else
                it.op = CMD_INSERT;
            pending_items.push_back(it);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while ((pending_items.size() != 0 || item_valid || exp_count != got_count)
               && cycles < LIMIT)
            @(negedge clk);
        timed_out = (cycles >= LIMIT);
        if (!timed_out)
            repeat (TAIL) @(negedge clk);

        if (timed_out)
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, exp_count - got_count);
        if (tree_results.size() != 0)
        begin
            errors += tree_results.size();
            $display("%0d expected results never arrived", tree_results.size());
        end

        $display("Run: %0d inserts, %0d dumps, %0d dropped codes; %0d results checked",
                 n_inserts, n_dumps, n_dropped, got_count);
        $display("  inserted %0d, duplicate %0d, overflow %0d, node %0d, empty %0d; errors %0d",
                 st_tally[ST_INSERTED], st_tally[ST_DUP], st_tally[ST_OVERFLOW],
                 st_tally[ST_NODE], st_tally[ST_EMPTY], errors);

        if (!timed_out && errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
